@@ src/jec_pkg.sv @@
package jec_pkg;

  // Field widths fixed by the pixel and register formats.
  localparam int START_W = 15;
  localparam int K_W     = 14;
  localparam int COLOR_W = 8;

  // Colour sequence: start value and step per iteration run.
  localparam logic [COLOR_W-1:0] COLOR_START = 8'd240;
  localparam logic [COLOR_W-1:0] COLOR_STEP  = 8'd16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_REAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_IMAG = 1'b1;

  // Control and colour that travel with each item along the chain.
  typedef struct packed {
    logic               valid;
    logic               done;
    logic [COLOR_W-1:0] color;
  } jec_tag_t;

endpackage

@@ src/jec_in_if.sv @@
interface jec_in_if import jec_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [START_W-1:0] start_real;
  logic signed [START_W-1:0] start_imag;

  modport source (output valid, output start_real, output start_imag, input ready);
  modport sink (input valid, input start_real, input start_imag, output ready);
endinterface

@@ src/jec_out_if.sv @@
interface jec_out_if import jec_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] color;

  modport source (output valid, output color, input ready);
  modport sink (input valid, input color, output ready);
endinterface

@@ src/julia_escape_color_top.sv @@
// Throughput: one item per cycle; each of the MAX_ITERATIONS cells runs one
// iteration in two stages (products, then update), and the chain only holds
// while the output register waits to be taken.
// Reset (synchronous, rst_n low) empties the chain and clears both constant
// registers to zero.
module julia_escape_color_top import jec_pkg::*; #(
  parameter int MAX_ITERATIONS = 16,
  parameter int FRACTION_BITS  = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  jec_in_if.sink               in_ch,
  jec_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [K_W-1:0]       cfg_data
);

  // Width of a point that has not escaped, and of one iteration further.
  localparam int ZW0 = (FRACTION_BITS + 3 > START_W) ? FRACTION_BITS + 3 : START_W;
  localparam int GW  = (2 * ZW0 - FRACTION_BITS > K_W) ? 2 * ZW0 - FRACTION_BITS : K_W;
  localparam int ZW  = GW + 2;

  logic signed [K_W-1:0] k_real_r;
  logic signed [K_W-1:0] k_imag_r;

  logic                  en;
  logic                  out_valid_r;
  logic [COLOR_W-1:0]    out_color_r;

  jec_tag_t              tag_w [0:MAX_ITERATIONS];
  logic signed [ZW-1:0]  zr_w  [0:MAX_ITERATIONS];
  logic signed [ZW-1:0]  zi_w  [0:MAX_ITERATIONS];

  // Julia constant registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_real_r <= '0;
      k_imag_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_JULIA_REAL: k_real_r <= $signed(cfg_data);
        CFG_JULIA_IMAG: k_imag_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // The whole chain moves unless a result is waiting in the output register.
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // A new item enters the first cell with the starting colour.
  always_comb begin
    tag_w[0].valid = in_ch.valid;
    tag_w[0].done  = 1'b0;
    tag_w[0].color = COLOR_START;
  end
  assign zr_w[0] = ZW'(in_ch.start_real);
  assign zi_w[0] = ZW'(in_ch.start_imag);

  // One cell per iteration; the start point itself is never tested for escape.
  for (genvar g = 0; g < MAX_ITERATIONS; g++) begin : g_cell
    jec_cell #(
      .FRAC (FRACTION_BITS),
      .ZW   (ZW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .check_en ((g != 0) ? 1'b1 : 1'b0),
      .k_real   (k_real_r),
      .k_imag   (k_imag_r),
      .tag_i    (tag_w[g]),
      .zr_i     (zr_w[g]),
      .zi_i     (zi_w[g]),
      .tag_o    (tag_w[g+1]),
      .zr_o     (zr_w[g+1]),
      .zi_o     (zi_w[g+1])
    );
  end

  // Output register holding the finished colour.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tag_w[MAX_ITERATIONS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_color_r <= tag_w[MAX_ITERATIONS].color;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.color = out_color_r;

endmodule

@@ src/jec_cell.sv @@
module jec_cell import jec_pkg::*; #(
  parameter int FRAC = 12,
  parameter int ZW   = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  check_en,
  input  logic signed [K_W-1:0] k_real,
  input  logic signed [K_W-1:0] k_imag,
  input  jec_tag_t              tag_i,
  input  logic signed [ZW-1:0]  zr_i,
  input  logic signed [ZW-1:0]  zi_i,
  output jec_tag_t              tag_o,
  output logic signed [ZW-1:0]  zr_o,
  output logic signed [ZW-1:0]  zi_o
);

  localparam int PW = 2 * ZW;
  localparam logic [PW:0] LIMIT = (PW + 1)'(1) << (2 * FRAC + 2);

  jec_tag_t              p_tag_r;
  logic signed [PW-1:0]  sq_re_r;
  logic signed [PW-1:0]  sq_im_r;
  logic signed [PW-1:0]  cross_r;

  logic [PW:0]           mag;
  logic                  escaped;
  logic                  stop;
  logic signed [PW:0]    diff;
  logic signed [ZW-1:0]  nr;
  logic signed [ZW-1:0]  ni;

  jec_tag_t              z_tag_r, z_tag_nxt;
  logic signed [ZW-1:0]  zr_r, zr_nxt;
  logic signed [ZW-1:0]  zi_r, zi_nxt;

  // Product stage: squares and cross product of the incoming point.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_tag_r <= '0;
    end else if (en) begin
      p_tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_re_r <= zr_i * zr_i;
      sq_im_r <= zi_i * zi_i;
      cross_r <= zr_i * zi_i;
    end
  end

  // The squares of the incoming point give its magnitude for the escape test.
  assign mag     = {1'b0, sq_re_r} + {1'b0, sq_im_r};
  assign escaped = check_en && (mag > LIMIT);
  assign stop    = p_tag_r.done || escaped;

  // New point: real and imaginary parts after the floor shifts, plus the constant.
  assign diff = $signed({sq_re_r[PW-1], sq_re_r}) - $signed({sq_im_r[PW-1], sq_im_r});
  assign nr   = ZW'(diff >>> FRAC) + ZW'(k_real);
  assign ni   = ZW'(cross_r >>> (FRAC - 1)) + ZW'(k_imag);

  // An item that has escaped passes on with its colour unchanged.
  always_comb begin
    z_tag_nxt      = p_tag_r;
    z_tag_nxt.done = stop;
    if (!stop) begin
      z_tag_nxt.color = p_tag_r.color + COLOR_STEP;
    end
    zr_nxt = nr;
    zi_nxt = ni;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_tag_r <= '0;
    end else if (en) begin
      z_tag_r <= z_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zr_r <= zr_nxt;
      zi_r <= zi_nxt;
    end
  end

  assign tag_o = z_tag_r;
  assign zr_o  = zr_r;
  assign zi_o  = zi_r;

endmodule

@@ bench/julia_escape_color_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels and the constant write port, predicts the color of
// every accepted pixel and compares it with the results as they come out.
module julia_escape_color_checker import jec_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  jec_in_if                    in_mon,
  jec_out_if                   out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [K_W-1:0]       cfg_data,
  output int                   mismatches,
  output int                   pending
);

  localparam int    MAX_ITERATIONS = 16;
  localparam int    FRACTION_BITS  = 12;
  localparam longint ESCAPE_LIMIT  = longint'(4) << (2 * FRACTION_BITS);

  logic signed [K_W-1:0] k_real;
  logic signed [K_W-1:0] k_imag;
  logic [COLOR_W-1:0]    expected_colors[$];
  int                    error_total;

  // Escape-time color of one pixel: iterate z = z*z + k with floor shifts and
  // stop after the first iteration whose |z|^2 passes 4.0.
  function automatic logic [COLOR_W-1:0] escape_color(
    input logic signed [START_W-1:0] re0,
    input logic signed [START_W-1:0] im0,
    input logic signed [K_W-1:0]     kr,
    input logic signed [K_W-1:0]     ki
  );
    longint             zr;
    longint             zi;
    longint             nr;
    longint             ni;
    longint             mag;
    logic [COLOR_W-1:0] color;
    zr = re0;
    zi = im0;
    color = COLOR_START;
    for (int n = 0; n < MAX_ITERATIONS; n++) begin
      nr = ((zr * zr - zi * zi) >>> FRACTION_BITS) + longint'(kr);
      ni = ((zr * zi) >>> (FRACTION_BITS - 1)) + longint'(ki);
      mag = nr * nr + ni * ni;
      zr = nr;
      zi = ni;
      color = color + COLOR_STEP;
      if (mag > ESCAPE_LIMIT) break;
    end
    return color;
  endfunction

  initial begin
    mismatches = 0;
    pending = 0;
    error_total = 0;
    k_real = '0;
    k_imag = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_colors.delete();
      k_real = '0;
      k_imag = '0;
    end else begin
      // A result item is checked against the oldest prediction.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_colors.size() == 0) begin
          error_total++;
          $display("%0t: color %0d arrived with no pixel outstanding", $time,
                   out_mon.color);
        end else if (out_mon.color !== expected_colors[0]) begin
          error_total++;
          $display("%0t: color mismatch, expected %0d, actual %0d", $time,
                   expected_colors[0], out_mon.color);
          void'(expected_colors.pop_front());
        end else begin
          void'(expected_colors.pop_front());
        end
      end

      // Each accepted pixel item gets its prediction with the current constant.
      if (in_mon.valid && in_mon.ready) begin
        expected_colors.push_back(escape_color(in_mon.start_real, in_mon.start_imag,
                                               k_real, k_imag));
      end

      // Constant writes take effect for items accepted after this edge.
      if (cfg_we) begin
        if (cfg_index == CFG_JULIA_REAL) begin
          k_real = cfg_data;
        end else if (cfg_index == CFG_JULIA_IMAG) begin
          k_imag = cfg_data;
        end
      end
    end
    mismatches <= error_total;
    pending <= expected_colors.size();
  end

endmodule

@@ bench/julia_escape_color_top_tb.sv @@
`timescale 1ns / 100ps

module julia_escape_color_top_tb;
  import jec_pkg::*;

  localparam int LATENCY      = 2 * 16 + 1;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 245;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [K_W-1:0]       cfg_data;
  int                   mismatches;
  int                   pending;
  int                   quiet_cycles;
  int                   stall_left;
  bit                   stall_enable;
  int                   gap_odds;

  // Corner pixels tried first with the constant at its reset value of zero.
  int directed_points[20][2] = '{
    '{0, 0}, '{4096, 0}, '{-4096, 0}, '{0, 4096}, '{0, -4096},
    '{8192, 0}, '{0, 8192}, '{-8192, -8192}, '{16383, 16383}, '{-16384, -16384},
    '{16383, -16384}, '{-16384, 16383}, '{1, -1}, '{-1, 1}, '{2048, 2048},
    '{2896, 2896}, '{5793, 0}, '{3000, -1500}, '{-2048, 3547}, '{8191, 1}
  };

  jec_in_if  in_ch ();
  jec_out_if out_ch ();

  julia_escape_color_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  julia_escape_color_checker color_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result side: ready drops in random bursts while stalls are enabled.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_ch.ready <= 1'b1;
    end else if (stall_enable && $urandom_range(0, 9) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(1, 18);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Ends the run when neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one pixel, possibly after an idle burst, and holds it until taken.
  task automatic offer_pixel(input logic signed [START_W-1:0] re,
                             input logic signed [START_W-1:0] im);
    if (gap_odds > 0 && $urandom_range(1, 100) <= gap_odds) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.start_real <= re;
    in_ch.start_imag <= im;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Mostly points within +/-2.0 on each axis, where escape times vary most.
  function automatic logic [START_W-1:0] pick_coord();
    logic [START_W-1:0] v;
    int                 pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) v = START_W'($urandom_range(0, 16383) - 8192);
    else if (pick < 8) v = START_W'($urandom_range(0, 8191) - 4096);
    else v = START_W'($urandom);
    return v;
  endfunction

  // Waits for every outstanding result, then lets the pipeline settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic load_constant(input logic [K_W-1:0] re, input logic [K_W-1:0] im);
    cfg_we <= 1'b1;
    cfg_index <= CFG_JULIA_REAL;
    cfg_data <= re;
    @(posedge clk);
    cfg_index <= CFG_JULIA_IMAG;
    cfg_data <= im;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int count, input bit idle);
    stall_enable = idle;
    for (int i = 0; i < count; i++) begin
      if (idle && i % 60 == 0) gap_odds = $urandom_range(0, 2) * 15;
      else if (!idle) gap_odds = 0;
      offer_pixel(pick_coord(), pick_coord());
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_JULIA_REAL;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.start_real = '0;
    in_ch.start_imag = '0;
    out_ch.ready = 1'b0;
    quiet_cycles = 0;
    stall_left = 0;
    stall_enable = 1'b1;
    gap_odds = 20;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Constant at reset value: corner pixels, then random ones.
    foreach (directed_points[i]) begin
      offer_pixel(START_W'(directed_points[i][0]), START_W'(directed_points[i][1]));
    end
    run_phase(PHASE_ITEMS - 20, 1'b1);

    // A familiar constant with a detailed boundary, then the range extremes.
    load_constant(K_W'(-3277), K_W'(639));
    run_phase(PHASE_ITEMS, 1'b1);
    load_constant(K_W'(4096), K_W'(4096));
    run_phase(PHASE_ITEMS, 1'b1);
    load_constant(K_W'(-4096), K_W'(-4096));
    run_phase(PHASE_ITEMS, 1'b1);

    // Encodings beyond the nominal range are used as raw 14-bit values.
    load_constant(K_W'(-8192), K_W'(8191));
    run_phase(PHASE_ITEMS, 1'b1);

    load_constant(K_W'($urandom_range(0, 8192) - 4096), K_W'($urandom_range(0, 8192) - 4096));
    run_phase(PHASE_ITEMS, 1'b1);

    // Final stretch runs at full rate on both sides.
    load_constant(K_W'($urandom_range(0, 8192) - 4096), K_W'($urandom_range(0, 8192) - 4096));
    run_phase(PHASE_ITEMS, 1'b0);

    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
